// File: hdl/grk4_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and the microcode decode of the rk4 generator stepper
// no dependencies

package grk4_pkg;

  localparam int NUM_GENERATORS = 16;
  localparam int NSTATE = 7;
  localparam int NCOEF = 12;
  localparam int SADDR_W = $clog2(NUM_GENERATORS * NSTATE);
  localparam int CADDR_W = $clog2(NUM_GENERATORS * NCOEF);
  localparam int SCR_DEPTH = 64;

  localparam logic [31:0] STEP_RESET = 32'd42949673;
  localparam logic signed [47:0] OMEGA_Q = 48'sd1619164524543;
  localparam logic signed [47:0] QMAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] QMIN = 48'sh8000_0000_0000;

  // last microcode step of the copy phase and of each rk stage, and first steps of its accumulate and advance parts
  localparam logic [5:0] UOP_LAST_INIT = 6'd6;
  localparam logic [5:0] UOP_LAST = 6'd51;
  localparam logic [5:0] UOP_ACC = 6'd24;
  localparam logic [5:0] UOP_ADV = 6'd38;

  // operand addresses: bit 6 selects a held register instead of scratch
  localparam logic [6:0] A_X = 7'd0;
  localparam logic [6:0] A_XS = 7'd8;
  localparam logic [6:0] A_C = 7'd16;
  localparam logic [6:0] A_SUM = 7'd32;
  localparam logic [6:0] A_K = 7'd40;
  localparam logic [6:0] A_T0 = 7'd48;
  localparam logic [6:0] A_T1 = 7'd49;
  localparam logic [6:0] A_ID = 7'd64;
  localparam logic [6:0] A_IQ = 7'd65;
  localparam logic [6:0] A_PM = 7'd66;
  localparam logic [6:0] A_PE = 7'd67;
  localparam logic [6:0] A_VE = 7'd68;
  localparam logic [6:0] A_H = 7'd69;
  localparam logic [6:0] A_DT = 7'd70;
  localparam logic [6:0] A_S = 7'd71;
  localparam logic [6:0] A_OM = 7'd72;

  typedef enum logic [1:0] {
    CMD_COEF = 2'd0,
    CMD_STATE = 2'd1,
    CMD_STEP = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    OP_MOV,
    OP_ADD,
    OP_SUB,
    OP_NEG,
    OP_MUL
  } alu_op_t;

  typedef struct packed {
    alu_op_t op;
    logic [6:0] a;
    logic [6:0] b;
    logic [6:0] d;
  } uop_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WAIT,
    S_PREP,
    S_ISSUE,
    S_EXEC,
    S_MUL
  } seq_state_t;

  typedef enum logic [1:0] {
    MUL_IDLE,
    MUL_RUN,
    MUL_RND,
    MUL_FIN
  } mul_state_t;

  typedef struct packed {
    logic start;
    logic signed [47:0] a;
    logic signed [47:0] b;
  } mul_req_t;

  function automatic uop_t mk(alu_op_t op, logic [6:0] a, logic [6:0] b, logic [6:0] d);
    uop_t u;
    u.op = op;
    u.a = a;
    u.b = b;
    u.d = d;
    return u;
  endfunction

  function automatic logic signed [47:0] sat49(logic signed [48:0] v);
    logic signed [47:0] r;
    if (v > 49'sh0_7FFF_FFFF_FFFF) r = QMAX;
    else if (v < -49'sh0_8000_0000_0000) r = QMIN;
    else r = v[47:0];
    return r;
  endfunction

  function automatic logic signed [47:0] alu_calc(alu_op_t op, logic signed [47:0] a,
                                                  logic signed [47:0] b);
    logic signed [48:0] ea;
    logic signed [48:0] eb;
    logic signed [48:0] s;
    ea = {a[47], a};
    eb = {b[47], b};
    case (op)
      OP_ADD: s = ea + eb;
      OP_SUB: s = ea - eb;
      OP_NEG: s = -ea;
      default: s = ea;
    endcase
    return sat49(s);
  endfunction

  // one microcode word per (phase, stage, step)
  function automatic uop_t decode_uop(logic init, logic [1:0] stage, logic [5:0] j);
    uop_t u;
    logic [5:0] r;
    logic [6:0] i;
    logic [6:0] m;
    r = (j >= UOP_ADV) ? j - UOP_ADV : j - UOP_ACC;
    i = {4'b0000, r[3:1]};
    case (stage)
      2'd2: m = A_DT;
      2'd3: m = A_S;
      default: m = A_H;
    endcase
    u = mk(OP_MOV, A_T0, A_T0, A_T0);
    if (init) begin
      u = mk(OP_MOV, A_X + {1'b0, j}, A_X, A_XS + {1'b0, j});
    end else if (j >= UOP_ADV) begin
      if (!r[0]) u = mk(OP_MUL, m, (stage == 2'd3) ? A_SUM + i : A_K + i, A_T0);
      else u = mk(OP_ADD, A_X + i, A_T0, (stage == 2'd3) ? A_X + i : A_XS + i);
    end else if (j >= UOP_ACC) begin
      if (!r[0]) begin
        if (stage == 2'd1 || stage == 2'd2) u = mk(OP_ADD, A_K + i, A_K + i, A_T0);
        else u = mk(OP_MOV, A_K + i, A_K + i, A_T0);
      end else begin
        if (stage == 2'd0) u = mk(OP_MOV, A_T0, A_T0, A_SUM + i);
        else u = mk(OP_ADD, A_SUM + i, A_T0, A_SUM + i);
      end
    end else begin
      case (j)
        6'd0: u = mk(OP_MUL, A_ID, A_C + 7'd4, A_T0);
        6'd1: u = mk(OP_SUB, A_XS + 7'd6, A_XS + 7'd0, A_T1);
        6'd2: u = mk(OP_ADD, A_T1, A_T0, A_T1);
        6'd3: u = mk(OP_MUL, A_T1, A_C + 7'd0, A_K + 7'd0);
        6'd4: u = mk(OP_MUL, A_IQ, A_C + 7'd5, A_T0);
        6'd5: u = mk(OP_ADD, A_XS + 7'd1, A_T0, A_T1);
        6'd6: u = mk(OP_NEG, A_T1, A_T1, A_T1);
        6'd7: u = mk(OP_MUL, A_T1, A_C + 7'd1, A_K + 7'd1);
        6'd8: u = mk(OP_MUL, A_ID, A_C + 7'd6, A_T0);
        6'd9: u = mk(OP_SUB, A_XS + 7'd0, A_XS + 7'd2, A_T1);
        6'd10: u = mk(OP_ADD, A_T1, A_T0, A_T1);
        6'd11: u = mk(OP_MUL, A_T1, A_C + 7'd2, A_K + 7'd2);
        6'd12: u = mk(OP_MUL, A_IQ, A_C + 7'd7, A_T0);
        6'd13: u = mk(OP_SUB, A_XS + 7'd1, A_XS + 7'd3, A_T1);
        6'd14: u = mk(OP_ADD, A_T1, A_T0, A_T1);
        6'd15: u = mk(OP_MUL, A_T1, A_C + 7'd3, A_K + 7'd3);
        6'd16: u = mk(OP_MUL, A_OM, A_XS + 7'd5, A_K + 7'd4);
        6'd17: u = mk(OP_SUB, A_PM, A_PE, A_T0);
        6'd18: u = mk(OP_MUL, A_T0, A_C + 7'd8, A_T0);
        6'd19: u = mk(OP_MUL, A_C + 7'd11, A_XS + 7'd5, A_T1);
        6'd20: u = mk(OP_SUB, A_T0, A_T1, A_K + 7'd5);
        6'd21: u = mk(OP_MUL, A_C + 7'd9, A_VE, A_T0);
        6'd22: u = mk(OP_SUB, A_T0, A_XS + 7'd6, A_T0);
        6'd23: u = mk(OP_MUL, A_T0, A_C + 7'd10, A_K + 7'd6);
        default: u = mk(OP_MOV, A_T0, A_T0, A_T0);
      endcase
    end
    return u;
  endfunction

endpackage

// File: hdl/grk4_ram.sv
`timescale 1ns / 1ps
// generic ram: one write port, two registered read ports
// no dependencies

module grk4_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// File: hdl/grk4_mul.sv
`timescale 1ns / 1ps
// bit-serial saturating q16.32 multiplier, one multiplier bit per cycle
// depends on grk4_pkg

module grk4_mul
  import grk4_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  mul_req_t           req,
  output logic               done,
  output logic signed [47:0] result
);

  mul_state_t st, st_next;
  logic [5:0] cnt;
  logic [47:0] mc;
  logic [47:0] acc_hi;
  logic [47:0] acc_lo;
  logic neg;
  logic [63:0] rnd;
  logic [48:0] sum;
  logic big;

  always_comb begin
    st_next = st;
    case (st)
      MUL_IDLE: if (req.start) st_next = MUL_RUN;
      MUL_RUN: if (cnt == 6'd47) st_next = MUL_RND;
      MUL_RND: st_next = MUL_FIN;
      MUL_FIN: st_next = MUL_IDLE;
      default: st_next = MUL_IDLE;
    endcase
  end

  always_comb begin
    sum = {1'b0, acc_hi} + (acc_lo[0] ? {1'b0, mc} : 49'd0);
    big = |rnd[63:47];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= MUL_IDLE;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      st <= st_next;
      done <= (st == MUL_FIN);
      cnt <= (st == MUL_RUN) ? cnt + 6'd1 : 6'd0;
    end
  end

  always_ff @(posedge clk) begin
    case (st)
      MUL_IDLE: begin
        mc <= req.a[47] ? 48'(-req.a) : req.a;
        acc_lo <= req.b[47] ? 48'(-req.b) : req.b;
        acc_hi <= '0;
        neg <= req.a[47] ^ req.b[47];
      end
      MUL_RUN: begin
        acc_hi <= sum[48:1];
        acc_lo <= {sum[0], acc_lo[47:1]};
      end
      MUL_RND: rnd <= {acc_hi, acc_lo[47:32]} + {63'd0, acc_lo[31]};
      MUL_FIN: begin
        if (neg) result <= big ? QMIN : -$signed(rnd[47:0]);
        else result <= big ? QMAX : $signed(rnd[47:0]);
      end
      default: ;
    endcase
  end

endmodule

// File: hdl/grk4_div6.sv
`timescale 1ns / 1ps
// restoring divide by six, one dividend bit per cycle, gives the rk weight step
// depends on grk4_pkg

module grk4_div6
  import grk4_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [32:0] dividend,
  output logic        busy,
  output logic [32:0] quotient
);

  logic [32:0] dvd;
  logic [2:0] rem;
  logic [5:0] cnt;
  logic [3:0] t;
  logic ge;

  always_comb begin
    t = {rem, dvd[32]};
    ge = (t >= 4'd6);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= '0;
    end else if (busy) begin
      cnt <= cnt + 6'd1;
      if (cnt == 6'd32) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[31:0], 1'b0};
      rem <= ge ? 3'(t - 4'd6) : t[2:0];
      quotient <= {quotient[31:0], ge};
    end
  end

endmodule

// File: hdl/generator_rk4_state_step.sv
`timescale 1ns / 1ps
// seven-state generator model advanced by one rk4 step, microcoded over a bit-serial multiplier
// a step loads coefficients and state into scratch while dividing dt by six, copies the state,
// then runs the rk stages, using the bit-serial multiplier 80 times; in_stall is high from
// acceptance until the step finishes, so no new step or load is taken while one is running
// depends on grk4_pkg, grk4_ram, grk4_mul, grk4_div6
// rst is synchronous: control state clears and step_size returns to STEP_RESET, stores keep contents until written

module generator_rk4_state_step
  import grk4_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         cmd,
  input  logic [3:0]         gen_index,
  input  logic [3:0]         slot,
  input  logic signed [47:0] load_value,
  input  logic signed [47:0] d_current,
  input  logic signed [47:0] q_current,
  input  logic signed [47:0] mech_power,
  input  logic signed [47:0] elec_power,
  input  logic signed [47:0] voltage_error,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [31:0]        cfg_data,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [3:0]         out_gen,
  output logic signed [47:0] q_transient,
  output logic signed [47:0] d_transient,
  output logic signed [47:0] q_subtransient,
  output logic signed [47:0] d_subtransient,
  output logic signed [47:0] rotor_angle,
  output logic signed [47:0] rotor_slip,
  output logic signed [47:0] field_voltage
);

  seq_state_t state, state_next;
  logic [31:0] step_size;
  logic [3:0] g;
  logic signed [47:0] op_id, op_iq, op_pm, op_pe, op_ve;
  logic init;
  logic [1:0] stage;
  logic [5:0] j;
  logic [4:0] pc;
  logic signed [47:0] res [NSTATE];

  logic accept;
  logic gen_ok;
  uop_t uop;
  logic [47:0] scr_rdata_a, scr_rdata_b;
  logic scr_we;
  logic [5:0] scr_waddr;
  logic [47:0] scr_wdata;
  logic signed [47:0] opa, opb;
  logic signed [47:0] alu_res, op_res;
  logic op_done, last_op, final_wr;
  logic [2:0] fin_idx;
  logic [4:0] item;
  mul_req_t mul_req;
  logic mul_done;
  logic signed [47:0] mul_result;
  logic div_start, div_busy;
  logic [32:0] quo;
  logic st_we, coef_we;
  logic [SADDR_W-1:0] st_waddr, st_raddr;
  logic [CADDR_W-1:0] coef_waddr, coef_raddr;
  logic [47:0] st_wdata;
  logic [47:0] st_rdata, coef_rdata;
  logic [4:0] st_slot, coef_slot;

  function automatic logic signed [47:0] held(logic [3:0] idx, logic signed [47:0] id,
                                              logic signed [47:0] iq, logic signed [47:0] pm,
                                              logic signed [47:0] pe, logic signed [47:0] ve,
                                              logic [31:0] dt, logic [32:0] s);
    logic signed [47:0] v;
    case ({3'b100, idx})
      A_ID: v = id;
      A_IQ: v = iq;
      A_PM: v = pm;
      A_PE: v = pe;
      A_VE: v = ve;
      A_H: v = {17'd0, dt[31:1]};
      A_DT: v = {16'd0, dt};
      A_S: v = {15'd0, s};
      A_OM: v = OMEGA_Q;
      default: v = '0;
    endcase
    return v;
  endfunction

  assign accept = in_valid && !in_stall;
  assign gen_ok = int'(gen_index) < NUM_GENERATORS;
  assign cfg_ready = 1'b1;
  assign uop = decode_uop(init, stage, j);
  assign last_op = !init && stage == 2'd3 && j == UOP_LAST;
  assign final_wr = !init && stage == 2'd3 && j >= UOP_ADV && j[0];
  assign fin_idx = 3'((j - UOP_ADV) >> 1);
  assign item = pc - 5'd1;
  assign coef_slot = (pc < 5'(NCOEF)) ? pc : 5'd0;
  assign st_slot = (pc >= 5'(NCOEF)) ? pc - 5'(NCOEF) : 5'd0;

  assign opa = uop.a[6] ? held(uop.a[3:0], op_id, op_iq, op_pm, op_pe, op_ve, step_size, quo)
                        : scr_rdata_a;
  assign opb = uop.b[6] ? held(uop.b[3:0], op_id, op_iq, op_pm, op_pe, op_ve, step_size, quo)
                        : scr_rdata_b;
  assign alu_res = alu_calc(uop.op, opa, opb);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (accept && cmd == CMD_STEP && gen_ok) state_next = S_WAIT;
      S_WAIT: if (!out_valid) state_next = S_PREP;
      S_PREP: if (pc == 5'd20 && !div_busy) state_next = S_ISSUE;
      S_ISSUE: state_next = S_EXEC;
      S_EXEC: begin
        if (uop.op == OP_MUL) state_next = S_MUL;
        else state_next = last_op ? S_IDLE : S_ISSUE;
      end
      S_MUL: if (mul_done) state_next = last_op ? S_IDLE : S_ISSUE;
      default: state_next = S_IDLE;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    in_stall = (state != S_IDLE);
    div_start = (state == S_WAIT) && !out_valid;
    mul_req.start = (state == S_EXEC) && (uop.op == OP_MUL);
    mul_req.a = opa;
    mul_req.b = opb;
    op_done = (state == S_EXEC && uop.op != OP_MUL) || (state == S_MUL && mul_done);
    op_res = (state == S_MUL) ? mul_result : alu_res;

    scr_we = 1'b0;
    scr_waddr = uop.d[5:0];
    scr_wdata = op_res;
    if (state == S_PREP && pc >= 5'd1 && pc <= 5'(NCOEF + NSTATE)) begin
      scr_we = 1'b1;
      if (item < 5'(NCOEF)) begin
        scr_waddr = A_C[5:0] + {1'b0, item};
        scr_wdata = coef_rdata;
      end else begin
        scr_waddr = A_X[5:0] + {1'b0, item - 5'(NCOEF)};
        scr_wdata = st_rdata;
      end
    end else if (op_done) begin
      scr_we = 1'b1;
    end

    coef_we = accept && cmd == CMD_COEF && gen_ok && slot < 4'(NCOEF);
    coef_waddr = CADDR_W'({gen_index, 3'b000}) + CADDR_W'({gen_index, 2'b00})
               + CADDR_W'(slot);
    coef_raddr = CADDR_W'({g, 3'b000}) + CADDR_W'({g, 2'b00}) + CADDR_W'(coef_slot);
    st_raddr = SADDR_W'({g, 3'b000}) - SADDR_W'(g) + SADDR_W'(st_slot);

    if (op_done && final_wr) begin
      st_we = 1'b1;
      st_waddr = SADDR_W'({g, 3'b000}) - SADDR_W'(g) + SADDR_W'(fin_idx);
      st_wdata = op_res;
    end else begin
      st_we = accept && cmd == CMD_STATE && gen_ok && slot < 4'(NSTATE);
      st_waddr = SADDR_W'({gen_index, 3'b000}) - SADDR_W'(gen_index) + SADDR_W'(slot);
      st_wdata = load_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step_size <= STEP_RESET;
      out_valid <= 1'b0;
      init <= 1'b0;
      stage <= '0;
      j <= '0;
      pc <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) step_size <= cfg_data;
      if (op_done && last_op) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      if (state == S_WAIT) pc <= '0;
      else if (state == S_PREP && pc != 5'd20) pc <= pc + 5'd1;
      if (state == S_PREP && state_next == S_ISSUE) begin
        init <= 1'b1;
        stage <= '0;
        j <= '0;
      end else if (op_done) begin
        if (init) begin
          if (j == UOP_LAST_INIT) begin
            init <= 1'b0;
            j <= '0;
          end else begin
            j <= j + 6'd1;
          end
        end else if (j == UOP_LAST) begin
          stage <= stage + 2'd1;
          j <= '0;
        end else begin
          j <= j + 6'd1;
        end
      end
    end
  end

  // transaction payload, step operands and step results
  always_ff @(posedge clk) begin
    if (accept) begin
      g <= gen_index;
      op_id <= d_current;
      op_iq <= q_current;
      op_pm <= mech_power;
      op_pe <= elec_power;
      op_ve <= voltage_error;
    end
    if (op_done && final_wr) res[fin_idx] <= op_res;
    if (op_done && last_op) out_gen <= g;
  end

  assign q_transient = res[0];
  assign d_transient = res[1];
  assign q_subtransient = res[2];
  assign d_subtransient = res[3];
  assign rotor_angle = res[4];
  assign rotor_slip = res[5];
  assign field_voltage = res[6];

  grk4_ram #(.WIDTH(48), .DEPTH(SCR_DEPTH)) u_scratch (
    .clk     (clk),
    .we      (scr_we),
    .waddr   (scr_waddr),
    .wdata   (scr_wdata),
    .raddr_a (uop.a[5:0]),
    .rdata_a (scr_rdata_a),
    .raddr_b (uop.b[5:0]),
    .rdata_b (scr_rdata_b)
  );

  grk4_ram #(.WIDTH(48), .DEPTH(NUM_GENERATORS * NSTATE)) u_states (
    .clk     (clk),
    .we      (st_we),
    .waddr   (st_waddr),
    .wdata   (st_wdata),
    .raddr_a (st_raddr),
    .rdata_a (st_rdata),
    .raddr_b ('0),
    .rdata_b ()
  );

  grk4_ram #(.WIDTH(48), .DEPTH(NUM_GENERATORS * NCOEF)) u_coefs (
    .clk     (clk),
    .we      (coef_we),
    .waddr   (coef_waddr),
    .wdata   (load_value),
    .raddr_a (coef_raddr),
    .rdata_a (coef_rdata),
    .raddr_b ('0),
    .rdata_b ()
  );

  grk4_mul u_mul (
    .clk    (clk),
    .rst    (rst),
    .req    (mul_req),
    .done   (mul_done),
    .result (mul_result)
  );

  grk4_div6 u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (33'(step_size) + 33'd3),
    .busy     (div_busy),
    .quotient (quo)
  );

`ifndef SYNTHESIS
  a_mul_done_in_mul: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> state == S_MUL) else $error("multiplier finished outside a multiply");
  a_prep_no_pending: assert property (@(posedge clk) disable iff (rst)
    state == S_PREP |-> !out_valid) else $error("step started over a pending result");
  a_idle_no_scratch: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !scr_we) else $error("scratch written while idle");
  a_result_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_EXEC || state == S_MUL))
    else $error("result raised without a finished step");
`endif

endmodule
